### hw/rtl/otw_pkg.sv
`default_nettype none

package otw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_WIN_BITS   = 16;
  localparam int OVL_BITS       = 9;
  localparam int CFG_IDX_BITS   = 8;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [OVL_BITS-1:0]     Q8_ONE          = OVL_BITS'(256);
  localparam logic [MAX_WIN_BITS-1:0] MAX_WINDOW_RST  = MAX_WIN_BITS'(1024);
  localparam logic [OVL_BITS-1:0]     OVERLAP_RST     = OVL_BITS'(64);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_WINDOW = 8'd0,
    CFG_OVERLAP_Q8 = 8'd1
  } cfg_idx_e;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_NEXT  = 1'b1
  } action_e;

  typedef struct packed {
    logic [MAX_WIN_BITS-1:0] max_window;
    logic [OVL_BITS-1:0]     overlap_q8;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/otw_if.sv
`default_nettype none

interface otw_in_if #(
  parameter int CW = 16
);
  logic          valid;
  logic          ready;
  logic          action;
  logic [CW-1:0] image_width;
  logic [CW-1:0] image_height;

  modport source (output valid, action, image_width, image_height, input ready);
  modport sink   (input valid, action, image_width, image_height, output ready);
endinterface

interface otw_out_if #(
  parameter int CW = 16
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] win_x;
  logic [CW-1:0] win_y;
  logic [CW-1:0] win_w;
  logic [CW-1:0] win_h;
  logic          is_last;
  logic          none;

  modport source (output valid, win_x, win_y, win_w, win_h, is_last, none, input ready);
  modport sink   (input valid, win_x, win_y, win_w, win_h, is_last, none, output ready);
endinterface

interface otw_cfg_if #(
  parameter int IW = 8,
  parameter int DW = 16
);
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/overlapping_tile_window_generator_unit.sv
`default_nettype none

// overlapping tile window generator: a start beat (action 0) loads an image
// size and returns the first window; every next beat (action 1) returns the
// following window in raster order, x as the inner axis. the window edge per
// axis is min(dimension, max_window) and the stride is
// floor(edge * (256 - overlap_q8) / 256), at least 1, with overlap_q8 above
// 256 treated as 256. each axis visits 0, step, 2*step, ... and always ends
// exactly at dimension minus edge. every input beat yields exactly one output
// beat; a start with a zero dimension or zero max_window, a next beat before
// any start, or a next beat after the last window gives a beat with none set
// and all other fields zero. is_last flags the final window of the image.
// throughput is one beat per cycle unless the result side stalls; a result
// goes from the input register through one combinational stage holding the
// stride multiply for starts and the add-and-clamp for nexts to the result
// register. with the result side stalled the two registers hold two beats
// before the input is held off. config writes (index 0 max_window, index 1
// overlap_q8, others ignored) are always accepted and only affect later
// start beats; write them while the block is idle.

module overlapping_tile_window_generator_unit
  import otw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  otw_cfg_if.sink      cfg_s,
  otw_in_if.sink       in_s,
  otw_out_if.source    out_m
);

  cfg_t cfg;

  // register file for window limit and overlap
  otw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_s.valid),
    .wr_ready_o (cfg_s.ready),
    .wr_index_i (cfg_s.index),
    .wr_data_i  (cfg_s.data),
    .cfg_o      (cfg)
  );

  // window walker: input register, compute stage, result register
  otw_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_s   (in_s),
    .out_m  (out_m)
  );

endmodule

`default_nettype wire

### hw/rtl/otw_cfg.sv
`default_nettype none

module otw_cfg
  import otw_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      wr_valid_i,
  output logic                     wr_ready_o,
  input  wire  [CFG_IDX_BITS-1:0]  wr_index_i,
  input  wire  [CFG_DATA_BITS-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_MAX_WINDOW: cfg_d.max_window = wr_data_i[MAX_WIN_BITS-1:0];
        CFG_OVERLAP_Q8: cfg_d.overlap_q8 = wr_data_i[OVL_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_window <= MAX_WINDOW_RST;
      cfg_q.overlap_q8 <= OVERLAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/otw_core.sv
`default_nettype none

module otw_core
  import otw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire cfg_t             cfg_i,
  otw_in_if.sink                in_s,
  otw_out_if.source             out_m
);

  localparam int CB = COORD_BITS;
  localparam int MW = (CB > MAX_WIN_BITS) ? CB : MAX_WIN_BITS;
  localparam int PW = CB + OVL_BITS;

  // input register
  logic          in_vld_q;
  logic          in_act_q;
  logic [CB-1:0] in_w_q;
  logic [CB-1:0] in_h_q;

  // walker state
  logic [CB-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [CB-1:0] size_x_q, size_x_d, size_y_q, size_y_d;
  logic [CB-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic          active_q, active_d;

  // result register
  logic          out_vld_q;
  logic [CB-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic [CB-1:0] res_w_q, res_w_d, res_h_q, res_h_d;
  logic          res_last_q, res_last_d;
  logic          res_none_q, res_none_d;

  logic          adv;
  logic          in_acc;

  logic [MW-1:0]       w_ext, h_ext, mw_ext;
  logic [CB-1:0]       sz_x, sz_y;
  logic [OVL_BITS-1:0] ovs, keep;
  logic [PW-1:0]       prod_x, prod_y;
  logic [CB:0]         sx, sy;
  logic [CB:0]         nx, ny;
  logic                start_bad;
  logic                fin;

  assign adv        = in_vld_q && (!out_vld_q || out_m.ready);
  assign in_s.ready = !in_vld_q || adv;
  assign in_acc     = in_s.valid && in_s.ready;

  // start: window size and step per axis
  assign w_ext  = MW'(in_w_q);
  assign h_ext  = MW'(in_h_q);
  assign mw_ext = MW'(cfg_i.max_window);
  assign sz_x   = (w_ext < mw_ext) ? in_w_q : CB'(mw_ext);
  assign sz_y   = (h_ext < mw_ext) ? in_h_q : CB'(mw_ext);
  assign ovs    = (cfg_i.overlap_q8 > Q8_ONE) ? Q8_ONE : cfg_i.overlap_q8;
  assign keep   = Q8_ONE - ovs;
  assign prod_x = PW'(sz_x) * PW'(keep);
  assign prod_y = PW'(sz_y) * PW'(keep);
  assign sx     = prod_x[PW-1:8];
  assign sy     = prod_y[PW-1:8];
  assign start_bad = (in_w_q == '0) || (in_h_q == '0) || (cfg_i.max_window == '0);

  // next: add and clamp
  assign nx = {1'b0, cur_x_q} + {1'b0, step_x_q};
  assign ny = {1'b0, cur_y_q} + {1'b0, step_y_q};

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    size_x_d = size_x_q;
    size_y_d = size_y_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    active_d = active_q;
    res_none_d = 1'b1;

    if (action_e'(in_act_q) == ACT_START) begin
      if (start_bad) begin
        active_d = 1'b0;
      end else begin
        size_x_d = sz_x;
        size_y_d = sz_y;
        step_x_d = (sx == '0) ? CB'(1) : sx[CB-1:0];
        step_y_d = (sy == '0) ? CB'(1) : sy[CB-1:0];
        last_x_d = in_w_q - sz_x;
        last_y_d = in_h_q - sz_y;
        cur_x_d  = '0;
        cur_y_d  = '0;
        active_d = 1'b1;
        res_none_d = 1'b0;
      end
    end else if (active_q) begin
      if (cur_x_q == last_x_q) begin
        cur_x_d = '0;
        cur_y_d = (ny > {1'b0, last_y_q}) ? last_y_q : ny[CB-1:0];
      end else begin
        cur_x_d = (nx > {1'b0, last_x_q}) ? last_x_q : nx[CB-1:0];
      end
      res_none_d = 1'b0;
    end

    fin = (cur_x_d == last_x_d) && (cur_y_d == last_y_d);
    if (!res_none_d && fin) begin
      active_d = 1'b0;
    end

    res_x_d    = res_none_d ? '0 : cur_x_d;
    res_y_d    = res_none_d ? '0 : cur_y_d;
    res_w_d    = res_none_d ? '0 : size_x_d;
    res_h_d    = res_none_d ? '0 : size_y_d;
    res_last_d = !res_none_d && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      step_x_q  <= CB'(1);
      step_y_q  <= CB'(1);
      size_x_q  <= '0;
      size_y_q  <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      active_q  <= 1'b0;
    end else begin
      if (in_s.ready) begin
        in_vld_q <= in_acc;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        step_x_q  <= step_x_d;
        step_y_q  <= step_y_d;
        size_x_q  <= size_x_d;
        size_y_q  <= size_y_d;
        last_x_q  <= last_x_d;
        last_y_q  <= last_y_d;
        active_q  <= active_d;
      end else if (out_m.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_act_q <= in_s.action;
      in_w_q   <= in_s.image_width;
      in_h_q   <= in_s.image_height;
    end
    if (adv) begin
      res_x_q    <= res_x_d;
      res_y_q    <= res_y_d;
      res_w_q    <= res_w_d;
      res_h_q    <= res_h_d;
      res_last_q <= res_last_d;
      res_none_q <= res_none_d;
    end
  end

  assign out_m.valid   = out_vld_q;
  assign out_m.win_x   = res_x_q;
  assign out_m.win_y   = res_y_q;
  assign out_m.win_w   = res_w_q;
  assign out_m.win_h   = res_h_q;
  assign out_m.is_last = res_last_q;
  assign out_m.none    = res_none_q;

endmodule

`default_nettype wire

### sim/overlapping_tile_window_generator_unit_tb.sv
`default_nettype none

module overlapping_tile_window_generator_unit_tb
  import otw_pkg::*;
;

  localparam int CW          = COORD_BITS_DEF;
  localparam int MAX_CYCLES  = 500000;
  localparam int NUM_PHASES  = 7;
  // first register index that the block does not decode
  localparam int SPARE_IDX_LO = int'(CFG_OVERLAP_Q8) + 1;
  localparam int SPARE_IDX_HI = (1 << CFG_IDX_BITS) - 1;

  // one output beat as the block should present it
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    logic          last;
    logic          none;
  } window_t;

  // tracks the tiling state of the block and the windows still owed by it
  class window_scoreboard;
    logic [MAX_WIN_BITS-1:0] max_win;
    logic [OVL_BITS-1:0]     overlap;
    logic [CW-1:0]           cur_x, cur_y, step_x, step_y;
    logic [CW-1:0]           size_x, size_y, last_x, last_y;
    bit                      active;
    window_t                 pending_windows[$];
    int                      n_errors, n_starts, n_windows, n_last, n_none;

    function new();
      max_win = MAX_WINDOW_RST;
      overlap = OVERLAP_RST;
      cur_x   = '0;
      cur_y   = '0;
      step_x  = CW'(1);
      step_y  = CW'(1);
      size_x  = '0;
      size_y  = '0;
      last_x  = '0;
      last_y  = '0;
      active  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == CFG_MAX_WINDOW) begin
        max_win = data[MAX_WIN_BITS-1:0];
      end else if (idx == CFG_OVERLAP_Q8) begin
        overlap = data[OVL_BITS-1:0];
      end
    endfunction

    function bit image_open();
      return active;
    endfunction

    function bit outstanding();
      return pending_windows.size() != 0;
    endfunction

    // stride on one axis, overlap saturated at one, never below one pixel
    function logic [CW-1:0] stride(logic [CW-1:0] span);
      int unsigned full, ov, sp, s;
      full = 32'(Q8_ONE);
      ov   = (overlap > Q8_ONE) ? full : 32'(overlap);
      sp   = 32'(span);
      s    = (sp * (full - ov)) >> 8;
      return (s == 0) ? CW'(1) : CW'(s);
    endfunction

    function window_t window_beat();
      window_t b;
      b      = '0;
      b.x    = cur_x;
      b.y    = cur_y;
      b.w    = size_x;
      b.h    = size_y;
      b.last = (cur_x == last_x) && (cur_y == last_y);
      if (b.last) begin
        active = 1'b0;
      end
      return b;
    endfunction

    function void note_request(action_e act, logic [CW-1:0] w, logic [CW-1:0] h);
      window_t     b;
      int unsigned nx, ny;
      b = '0;
      if (act == ACT_START) begin
        n_starts++;
        if (w == '0 || h == '0 || max_win == '0) begin
          active = 1'b0;
          b.none = 1'b1;
        end else begin
          size_x = (w < max_win) ? w : max_win;
          size_y = (h < max_win) ? h : max_win;
          step_x = stride(size_x);
          step_y = stride(size_y);
          last_x = w - size_x;
          last_y = h - size_y;
          cur_x  = '0;
          cur_y  = '0;
          active = 1'b1;
          b      = window_beat();
        end
      end else if (!active) begin
        b.none = 1'b1;
      end else begin
        if (cur_x == last_x) begin
          ny    = 32'(cur_y) + 32'(step_y);
          cur_x = '0;
          cur_y = (ny > 32'(last_y)) ? last_y : CW'(ny);
        end else begin
          nx    = 32'(cur_x) + 32'(step_x);
          cur_x = (nx > 32'(last_x)) ? last_x : CW'(nx);
        end
        b = window_beat();
      end
      pending_windows.insert(pending_windows.size(), b);
    endfunction

    function void field_check(string field, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_window(window_t got);
      window_t want;
      if (pending_windows.size() == 0) begin
        $error("window beat with nothing expected: x %0d y %0d none %0d",
               got.x, got.y, got.none);
        n_errors++;
        return;
      end
      want = pending_windows.pop_front();
      if (want.none) begin
        n_none++;
      end else begin
        n_windows++;
      end
      if (want.last) begin
        n_last++;
      end
      field_check("win_x", want.x, got.x);
      field_check("win_y", want.y, got.y);
      field_check("win_w", want.w, got.w);
      field_check("win_h", want.h, got.h);
      field_check("is_last", CW'(want.last), CW'(got.last));
      field_check("none", CW'(want.none), CW'(got.none));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  otw_cfg_if #(.IW(CFG_IDX_BITS), .DW(CFG_DATA_BITS)) cfg_if ();
  otw_in_if  #(.CW(CW))                                in_if ();
  otw_out_if #(.CW(CW))                                out_if ();

  overlapping_tile_window_generator_unit #(
    .COORD_BITS(CW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_s (cfg_if),
    .in_s  (in_if),
    .out_m (out_if)
  );

  window_scoreboard sb = new();
  int items_sent;
  int n_settings;
  // when set, the request side offers beats back to back
  bit burst;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // request side gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // image dimension: mostly at most a little over the window edge so that images
  // finish within a sequence, sometimes several windows wide, sometimes any
  function automatic logic [CW-1:0] pick_dim(logic [MAX_WIN_BITS-1:0] mw);
    int unsigned m, top;
    int          r;
    m = 32'(mw);
    r = $urandom_range(0, 9);
    if (m == 0 || r == 0) begin
      return CW'($urandom);
    end
    if (r < 6) begin
      top = m + m / 4 + 1;
    end else begin
      top = 4 * m;
    end
    if (top > 65535) begin
      top = 65535;
    end
    return CW'($urandom_range(1, top));
  endfunction

  // one request beat, entered and left at a rising edge
  task automatic send_item(action_e act, logic [CW-1:0] w, logic [CW-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.image_width  <= w;
    in_if.image_height <= h;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(act, w, h);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain: every owed window back, then an idle wait for the two-stage pipe
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.outstanding()) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tiling(logic [CFG_DATA_BITS-1:0] mw, logic [CFG_DATA_BITS-1:0] ov);
    settle();
    write_reg(CFG_OVERLAP_Q8, ov);
    // undecoded index, must leave both registers alone
    write_reg(CFG_IDX_BITS'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), CFG_DATA_BITS'($urandom));
    write_reg(CFG_MAX_WINDOW, mw);
    n_settings++;
  endtask

  // mostly start-then-walk sequences, some cut short by a new start,
  // the rest lone next beats and starts with arbitrary sizes
  task automatic run_random(int budget, logic [MAX_WIN_BITS-1:0] mw);
    int            stop_at, nexts, cap, r;
    logic [CW-1:0] w, h;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r     = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      if (r < 80) begin
        send_item(ACT_START, pick_dim(mw), pick_dim(mw));
        cap   = $urandom_range(1, 60);
        nexts = 0;
        while (sb.image_open() && nexts < cap) begin
          send_item(ACT_NEXT, CW'($urandom), CW'($urandom));
          nexts++;
        end
        // more next beats, which must give empty beats once the walk has passed the end
        repeat ($urandom_range(0, 2)) send_item(ACT_NEXT, CW'($urandom), CW'($urandom));
      end else if (r < 90) begin
        send_item(ACT_NEXT, CW'($urandom), CW'($urandom));
      end else begin
        w = ($urandom_range(0, 2) == 0) ? '0 : CW'($urandom);
        h = ($urandom_range(0, 2) == 0) ? '0 : CW'($urandom);
        send_item(ACT_START, w, h);
      end
      burst = 1'b0;
    end
  endtask

  // result side: check every accepted beat, stall at random, and hold off after beat 250
  // and every 450 beats after it, long enough for the pipe to fill and push back on requests
  initial begin
    int stall, free_run, seen, hold_mark, r;
    stall     = 0;
    free_run  = 0;
    seen      = 0;
    hold_mark = 250;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_window('{out_if.win_x, out_if.win_y, out_if.win_w, out_if.win_h,
                          out_if.is_last, out_if.none});
        seen++;
      end
      if (seen >= hold_mark) begin
        stall     = 150;
        hold_mark = hold_mark + 450;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (free_run > 0) begin
          free_run--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 60) begin
            stall = 0;
          end else if (r < 85) begin
            stall = $urandom_range(1, 3);
          end else if (r < 93) begin
            stall = $urandom_range(6, 25);
          end else begin
            free_run = $urandom_range(30, 80);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] mw, ov;
    int                       budget;
    rst_ni              <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_START;
    in_if.image_width   <= '0;
    in_if.image_height  <= '0;
    items_sent          = 0;
    n_settings          = 1;
    burst               = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tiling: next before any start, zero width, zero height
    send_item(ACT_NEXT, '1, '1);
    send_item(ACT_START, '0, '1);
    send_item(ACT_START, '1, '0);
    // single-pixel image is its own last window, next after it is empty
    send_item(ACT_START, CW'(1), CW'(1));
    send_item(ACT_NEXT, '0, '0);
    // largest image, window clamped to max_window
    send_item(ACT_START, '1, '1);
    repeat (3) send_item(ACT_NEXT, '0, '0);
    // stepping misses the far edge on both axes, so the edge start is added
    send_item(ACT_START, CW'(1500), CW'(1030));
    repeat (4) send_item(ACT_NEXT, '1, '0);

    // zero max_window turns every start into an empty beat
    set_tiling('0, CFG_DATA_BITS'(128));
    send_item(ACT_START, CW'(100), CW'(100));
    send_item(ACT_NEXT, CW'(100), CW'(100));

    // overlap above one saturates, stride drops to one pixel
    set_tiling(CFG_DATA_BITS'(8), CFG_DATA_BITS'(300));
    send_item(ACT_START, CW'(10), CW'(9));
    repeat (6) send_item(ACT_NEXT, '0, '1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      budget = 160;
      case (p)
        0: begin mw = CFG_DATA_BITS'(1);     ov = '0;                     end
        1: begin mw = CFG_DATA_BITS'(65535); ov = CFG_DATA_BITS'(Q8_ONE); end
        2: begin mw = '0; ov = CFG_DATA_BITS'(OVERLAP_RST); budget = 40; end
        3: begin mw = CFG_DATA_BITS'(16);    ov = CFG_DATA_BITS'(511);    end
        4: begin mw = CFG_DATA_BITS'(100);   ov = CFG_DATA_BITS'(128);    end
        5: begin
          mw = CFG_DATA_BITS'($urandom_range(1, 300));
          ov = CFG_DATA_BITS'($urandom_range(0, 511));
        end
        default: begin
          // upper data bits above the overlap field must be dropped
          mw = CFG_DATA_BITS'($urandom_range(2, 64));
          ov = CFG_DATA_BITS'($urandom);
        end
      endcase
      set_tiling(mw, ov);
      run_random(budget, mw[MAX_WIN_BITS-1:0]);
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("run: %0d requests (%0d starts) over %0d tiling settings",
             items_sent, sb.n_starts, n_settings);
    $display("run: %0d windows checked, %0d image ends, %0d empty beats, %0d errors",
             sb.n_windows, sb.n_last, sb.n_none, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
